FILE: sv/u8dec_pkg.sv
// ---------------------------------------------------------------------------
// u8dec_pkg
// Beat types and decode helpers shared by the UTF-8 decoder.
// ---------------------------------------------------------------------------
package u8dec_pkg;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam int unsigned MaxHeld     = 3;
    localparam int unsigned MaxResults  = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        last_of_text;
    } out_beat_t;

    // sequence length from the lead byte, zero for a bad lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0)
        begin
            len = 3'd1;
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            len = 3'd2;
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            len = 3'd3;
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [20:0] decode_seq(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] len
    );
        logic [20:0] cp;
        case (len)
            3'd1:    cp = {13'd0, b0};
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = REPLACEMENT;
        endcase
        return cp;
    endfunction

endpackage

FILE: sv/utf8_to_code_point_decoder.sv
// ---------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Decodes a UTF-8 byte stream into code points, one byte beat at a time.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | in_data  (in_byte, end_of_text)
//  out     | out_valid / out_ready  | out_data (code_point, last_of_text)
//
//  one byte per cycle unless stalled; results come from a registered buffer
//  the final byte of a text gives up to three code points, one per cycle when
//  out_ready is high; the input register waits while the buffer drains them
//  reset clears the open sequence, the input register and the result buffer
//  a stalled output holds the result buffer and then the input register
// ---------------------------------------------------------------------------
module utf8_to_code_point_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8dec_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8dec_pkg::out_beat_t out_data
);

    logic                 s1_valid_reg;
    u8dec_pkg::in_beat_t  s1_data_reg;

    logic [7:0]           held_reg [u8dec_pkg::MaxHeld];
    logic [1:0]           held_count_reg;
    logic [1:0]           held_count_next;
    logic [2:0]           seq_len_reg;
    logic [2:0]           seq_len_next;
    logic                 held_wr_en;
    logic [1:0]           held_wr_idx;

    u8dec_pkg::out_beat_t res_reg  [u8dec_pkg::MaxResults];
    u8dec_pkg::out_beat_t res_next [u8dec_pkg::MaxResults];
    logic [1:0]           res_cnt_reg;
    logic [1:0]           res_cnt_next;

    u8dec_pkg::out_beat_t gen      [u8dec_pkg::MaxResults];
    logic [1:0]           gen_cnt;

    logic                 out_take;
    logic                 s1_adv;
    logic                 in_take;

    assign out_valid = (res_cnt_reg != 2'd0);
    assign out_data  = res_reg[0];
    assign out_take  = out_valid & out_ready;
    assign s1_adv    = s1_valid_reg &
                       ((res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && out_take));
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_take   = in_valid & in_ready;

    // decode of the registered beat against the open sequence
    always_comb
    begin : decode_blk
        logic [7:0]  buf_b [4];
        logic [7:0]  b;
        logic [2:0]  h;
        logic [2:0]  n;
        logic [2:0]  pos;
        logic [2:0]  ln;
        logic [2:0]  p1;
        logic [2:0]  p2;
        logic [2:0]  p3;
        logic [1:0]  cnt;
        logic        full;
        logic [20:0] cp;

        b    = s1_data_reg.in_byte;
        h    = {1'b0, held_count_reg};
        n    = h + 3'd1;
        pos  = 3'd0;
        cnt  = 2'd0;
        full = 1'b0;
        cp   = u8dec_pkg::REPLACEMENT;
        ln   = 3'd0;
        p1   = 3'd0;
        p2   = 3'd0;
        p3   = 3'd0;

        for (int k = 0; k < 3; k++)
        begin
            if (k < h)
            begin
                buf_b[k] = held_reg[k];
            end
            else if (k == h)
            begin
                buf_b[k] = b;
            end
            else
            begin
                buf_b[k] = 8'd0;
            end
        end
        buf_b[3] = (h == 3'd3) ? b : 8'd0;

        for (int k = 0; k < u8dec_pkg::MaxResults; k++)
        begin
            gen[k] = '{code_point: u8dec_pkg::REPLACEMENT, last_of_text: 1'b0};
        end
        gen_cnt         = 2'd0;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        held_wr_en      = 1'b0;
        held_wr_idx     = held_count_reg;

        if (s1_data_reg.end_of_text)
        begin
            // held bytes plus this one are the whole rest of the text
            for (int k = 0; k < 4; k++)
            begin
                if ((pos < n) && !full)
                begin
                    ln = u8dec_pkg::lead_len(buf_b[pos[1:0]]);
                    p1 = pos + 3'd1;
                    p2 = pos + 3'd2;
                    p3 = pos + 3'd3;
                    if ((ln != 3'd0) && ((pos + ln) <= n))
                    begin
                        cp  = u8dec_pkg::decode_seq(buf_b[pos[1:0]], buf_b[p1[1:0]],
                                                    buf_b[p2[1:0]], buf_b[p3[1:0]], ln);
                        pos = pos + ln;
                    end
                    else
                    begin
                        cp  = u8dec_pkg::REPLACEMENT;
                        pos = pos + 3'd1;
                    end
                    gen[cnt].code_point = cp;
                    if (cnt == 2'd2)
                    begin
                        full = 1'b1;
                    end
                    else
                    begin
                        cnt = cnt + 2'd1;
                    end
                end
            end
            gen_cnt = full ? 2'd3 : cnt;
            gen[gen_cnt - 2'd1].last_of_text = 1'b1;
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
        end
        else if (seq_len_reg == 3'd0)
        begin
            ln = u8dec_pkg::lead_len(b);
            if (ln == 3'd1)
            begin
                gen[0].code_point = {13'd0, b};
                gen_cnt = 2'd1;
            end
            else if (ln == 3'd0)
            begin
                gen_cnt = 2'd1;
            end
            else
            begin
                held_wr_en      = 1'b1;
                held_wr_idx     = 2'd0;
                held_count_next = 2'd1;
                seq_len_next    = ln;
            end
        end
        else if (n == seq_len_reg)
        begin
            gen[0].code_point = u8dec_pkg::decode_seq(buf_b[0], buf_b[1], buf_b[2],
                                                      buf_b[3], seq_len_reg);
            gen_cnt         = 2'd1;
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
        end
        else
        begin
            held_wr_en      = 1'b1;
            held_wr_idx     = held_count_reg;
            held_count_next = n[1:0];
        end
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        for (int k = 0; k < u8dec_pkg::MaxResults; k++)
        begin
            res_next[k] = res_reg[k];
        end
        if (s1_adv)
        begin
            res_cnt_next = gen_cnt;
            for (int k = 0; k < u8dec_pkg::MaxResults; k++)
            begin
                res_next[k] = gen[k];
            end
        end
        else if (out_take)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
            res_next[0]  = res_reg[1];
            res_next[1]  = res_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                held_count_reg <= held_count_next;
                seq_len_reg    <= seq_len_next;
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv && held_wr_en)
        begin
            held_reg[held_wr_idx] <= s1_data_reg.in_byte;
        end
        for (int k = 0; k < u8dec_pkg::MaxResults; k++)
        begin
            res_reg[k] <= res_next[k];
        end
    end

`ifndef NO_ASSERTIONS
    // an open sequence always needs at least two bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg != 3'd1)
        else $error("single byte sequence left open");

    // held bytes stay short of the open sequence length
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg == 3'd0 && held_count_reg == 2'd0) ||
        (seq_len_reg != 3'd0 && {1'b0, held_count_reg} < seq_len_reg &&
         held_count_reg != 2'd0))
        else $error("held count out of step with sequence length");

    // the final byte closes the text and always gives a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_data_reg.end_of_text) |=>
        (seq_len_reg == 3'd0 && held_count_reg == 2'd0 && res_cnt_reg != 2'd0))
        else $error("end of text left state open or gave no result");

    // a marked last code point is the final one in the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last_of_text) |-> (res_cnt_reg == 2'd1))
        else $error("last code point shown ahead of others");
`endif

endmodule

FILE: test/tb_utf8_to_code_point_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_utf8_to_code_point_decoder
// Feeds byte texts through the UTF-8 decoder under random idling on both
// channels and checks every code point beat against a behavioural predictor
// of lead lengths, held bytes and end-of-text re-decoding.
// ---------------------------------------------------------------------------
class code_point_board;
    logic [7:0]           held [3];
    int unsigned          held_n;
    int unsigned          open_span;
    u8dec_pkg::out_beat_t pending_points [$];
    int                   errors;
    int                   bytes_seen;
    int                   texts_seen;
    int                   points_seen;
    int                   replacements_seen;

    function new();
        held_n = 0;
        open_span = 0;
        errors = 0;
        bytes_seen = 0;
        texts_seen = 0;
        points_seen = 0;
        replacements_seen = 0;
    endfunction

    function int unsigned lead_span(logic [7:0] b);
        if (b[7] == 1'b0)
            return 1;
        if (b[7:5] == 3'b110)
            return 2;
        if (b[7:4] == 4'b1110)
            return 3;
        if (b[7:3] == 5'b11110)
            return 4;
        return 0;
    endfunction

    function logic [20:0] join_bytes(logic [7:0] seq [4], int unsigned first,
                                     int unsigned span);
        logic [20:0] cp;
        int unsigned k;
        case (span)
            1:       cp = {13'd0, seq[first]};
            2:       cp = {16'd0, seq[first][4:0]};
            3:       cp = {17'd0, seq[first][3:0]};
            default: cp = {18'd0, seq[first][2:0]};
        endcase
        for (k = 1; k < span; k++)
        begin
            cp = {cp[14:0], seq[first + k][5:0]};
        end
        return cp;
    endfunction

    function void push_point(logic [20:0] cp, logic last);
        u8dec_pkg::out_beat_t beat;
        beat.code_point = cp;
        beat.last_of_text = last;
        pending_points = {pending_points, beat};
    endfunction

    function int pending();
        return pending_points.size();
    endfunction

    function void note_byte(u8dec_pkg::in_beat_t beat);
        logic [7:0]  seq [4];
        logic [20:0] pts [4];
        int unsigned n;
        int unsigned i;
        int unsigned span;
        int unsigned cnt;
        bytes_seen++;
        if (beat.end_of_text)
        begin
            // held bytes plus this one are the rest of the text
            texts_seen++;
            n = 0;
            for (i = 0; i < held_n; i++)
            begin
                seq[n] = held[i];
                n++;
            end
            seq[n] = beat.in_byte;
            n++;
            i = 0;
            cnt = 0;
            while (i < n && cnt < 4)
            begin
                span = lead_span(seq[i]);
                if (span != 0 && i + span <= n)
                begin
                    pts[cnt] = join_bytes(seq, i, span);
                    i += span;
                end
                else
                begin
                    pts[cnt] = u8dec_pkg::REPLACEMENT;
                    i++;
                end
                cnt++;
            end
            if (cnt > 3)
                cnt = 3;
            for (i = 0; i < cnt; i++)
            begin
                push_point(pts[i], i + 1 == cnt);
            end
            held_n = 0;
            open_span = 0;
        end
        else if (open_span == 0)
        begin
            span = lead_span(beat.in_byte);
            if (span == 1)
                push_point({13'd0, beat.in_byte}, 1'b0);
            else if (span == 0)
                push_point(u8dec_pkg::REPLACEMENT, 1'b0);
            else
            begin
                held[0] = beat.in_byte;
                held_n = 1;
                open_span = span;
            end
        end
        else if (held_n + 1 >= open_span)
        begin
            for (i = 0; i < held_n; i++)
            begin
                seq[i] = held[i];
            end
            seq[held_n] = beat.in_byte;
            push_point(join_bytes(seq, 0, open_span), 1'b0);
            held_n = 0;
            open_span = 0;
        end
        else
        begin
            held[held_n] = beat.in_byte;
            held_n++;
        end
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_point(u8dec_pkg::out_beat_t got);
        u8dec_pkg::out_beat_t want;
        points_seen++;
        if (got.code_point == u8dec_pkg::REPLACEMENT)
            replacements_seen++;
        if (pending_points.size() == 0)
        begin
            report($sformatf("code point %h with none expected", got.code_point));
        end
        else
        begin
            want = pending_points.pop_front();
            if (got.code_point != want.code_point)
                report($sformatf("code_point %h, expected %h",
                                 got.code_point, want.code_point));
            if (got.last_of_text != want.last_of_text)
                report($sformatf("last_of_text %b, expected %b on code point %h",
                                 got.last_of_text, want.last_of_text, want.code_point));
        end
    endtask
endclass

module tb_utf8_to_code_point_decoder;

    localparam int TextBytes = 480;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    u8dec_pkg::in_beat_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    u8dec_pkg::out_beat_t out_data;

    code_point_board board;
    logic            calm;
    int              bytes_sent;

    utf8_to_code_point_decoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("utf8_to_code_point_decoder regression: fail");
        $finish;
    end

    function automatic int idle_cycles();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_byte(in_data);
            if (out_valid && out_ready)
                board.check_point(out_data);
        end
    end

    // sink side stalls
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = idle_cycles();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{in_byte: b, end_of_text: eot};
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic drain_points();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_text();
        logic [7:0]  text_q [$];
        logic [7:0]  b;
        int unsigned chars;
        int unsigned c;
        int unsigned k;
        int unsigned span;
        int          r;
        chars = $urandom_range(1, 8);
        span = 1;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise text
            for (c = 0; c < chars * 2; c++)
            begin
                b = 8'($urandom_range(0, 255));
                text_q = {text_q, b};
            end
        end
        else
        begin
            for (c = 0; c < chars; c++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    span = 1;
                    if (r[0])
                        b = 8'h80 | 8'($urandom_range(0, 63));
                    else
                        b = 8'hF8 | 8'($urandom_range(0, 7));
                    text_q = {text_q, b};
                end
                else
                begin
                    span = (r < 40) ? 1 : (r < 60) ? 2 : (r < 80) ? 3 : 4;
                    case (span)
                        1:       b = 8'($urandom_range(0, 127));
                        2:       b = 8'hC0 | 8'($urandom_range(0, 31));
                        3:       b = 8'hE0 | 8'($urandom_range(0, 15));
                        default: b = 8'hF0 | 8'($urandom_range(0, 7));
                    endcase
                    text_q = {text_q, b};
                    for (k = 1; k < span; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            b = 8'($urandom_range(0, 255));
                        else
                            b = 8'h80 | 8'($urandom_range(0, 63));
                        text_q = {text_q, b};
                    end
                end
            end
            // cut the final sequence short now and then
            if (span > 1 && $urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, span - 1))
                    void'(text_q.pop_back());
            end
        end
        for (k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], k + 1 == text_q.size());
    endtask

    initial
    begin
        int guard;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        calm = 1'b1;
        bytes_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // single bytes at both ends, every sequence length, bad leads
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // truncated sequences at the end of a text
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // one-byte text, sequence closed by the final byte, bad final lead
        send_byte(8'h41, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'hF8, 1'b1);
        drain_points();

        while (bytes_sent < TextBytes)
        begin
            calm = ($urandom_range(0, 4) == 0);
            send_random_text();
            if ($urandom_range(0, 9) == 0)
                drain_points();
        end
        in_valid <= 1'b0;
        @(posedge clk);

        guard = 0;
        while (board.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (board.pending() != 0)
            board.report($sformatf("%0d code points never arrived", board.pending()));
        repeat (20) @(posedge clk);

        $display("covered %0d bytes in %0d texts, %0d code points checked",
                 board.bytes_seen, board.texts_seen, board.points_seen);
        $display("%0d of them replacement points from bad or cut-short leads",
                 board.replacements_seen);
        if (board.errors == 0)
            $display("utf8_to_code_point_decoder regression: pass");
        else
            $display("utf8_to_code_point_decoder regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/u8dec_pkg.sv
sv/utf8_to_code_point_decoder.sv
test/tb_utf8_to_code_point_decoder.sv
